// ----- rtl/core/button_auto_repeat_macros.svh -----
// assertion macros used by the button auto repeat top level
`ifndef BUTTON_AUTO_REPEAT_MACROS_SVH
`define BUTTON_AUTO_REPEAT_MACROS_SVH

// same-cycle implication, checked out of reset
`define BAR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("button_auto_repeat: same-cycle check failed");

// next-cycle implication, checked out of reset
`define BAR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("button_auto_repeat: next-cycle check failed");

`endif

// ----- rtl/core/bar_pkg.sv -----
// shared constants and types for the button auto repeat block
package bar_pkg;

    localparam int LANE_STRIDE = 6;
    localparam int LANES       = 12;
    localparam int LINE_W      = 12;
    localparam int CNT_W       = 9;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_IDX_W-1:0] REG_DELAY    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FAST     = 2'd2;

    localparam logic [CFG_DATA_W-1:0] DELAY_RST    = 8'd15;
    localparam logic [CFG_DATA_W-1:0] INTERVAL_RST = 8'd4;

    // scaled repeat timing seen by every lane
    typedef struct packed {
        logic [CNT_W-1:0] delay;
        logic [CNT_W-1:0] interval;
    } timing_t;

endpackage

// ----- rtl/core/bar_cfg.sv -----
// configuration registers and scaled delay / interval
module bar_cfg
    import bar_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output timing_t               timing
);

    logic [CFG_DATA_W-1:0] delay_reg;
    logic [CFG_DATA_W-1:0] interval_reg;
    logic                  fast_reg;
    logic [CNT_W-1:0]      delay_scaled;
    logic [CNT_W-1:0]      interval_scaled;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg    <= DELAY_RST;
            interval_reg <= INTERVAL_RST;
            fast_reg     <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_DELAY:    delay_reg    <= cfg_data;
                REG_INTERVAL: interval_reg <= cfg_data;
                REG_FAST:     fast_reg     <= cfg_data[0];
                default:      ;
            endcase
        end
    end

    // fast mode doubles both values
    always_comb
    begin
        if (fast_reg)
        begin
            delay_scaled    = {delay_reg, 1'b0};
            interval_scaled = {interval_reg, 1'b0};
        end
        else
        begin
            delay_scaled    = {1'b0, delay_reg};
            interval_scaled = {1'b0, interval_reg};
        end
    end

    assign timing.delay    = delay_scaled;
    assign timing.interval = (interval_scaled == '0) ? CNT_W'(1) : interval_scaled;

endmodule

// ----- rtl/core/bar_lane.sv -----
// hold counter and repeat phase for one button
module bar_lane
    import bar_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    update,
    input  logic    level,
    input  timing_t timing,
    output logic    press
);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] phase_reg;
    logic [CNT_W-1:0] phase_next;
    logic [CNT_W:0]   limit;
    logic [CNT_W:0]   count_inc;
    logic [CNT_W:0]   count_sat;
    logic [CNT_W:0]   phase_inc;

    always_comb
    begin
        limit     = {1'b0, timing.delay} + (CNT_W+1)'(1);
        count_inc = {1'b0, count_reg} + (CNT_W+1)'(1);
        phase_inc = {1'b0, phase_reg} + (CNT_W+1)'(1);
        // saturate at delay+1, also clamps after a shorter delay is written
        count_sat = (count_inc > limit) ? limit : count_inc;

        if (!level)
        begin
            count_next = '0;
            phase_next = '0;
        end
        else
        begin
            count_next = count_sat[CNT_W-1:0];
            if ({1'b0, count_reg} >= limit)
                phase_next = (phase_inc >= {1'b0, timing.interval}) ? '0
                                                                     : phase_inc[CNT_W-1:0];
            else
                phase_next = '0;
        end

        press = level && ((count_sat == (CNT_W+1)'(1))
                          || (count_sat == limit && phase_next == '0));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            phase_reg <= '0;
        end
        else if (update)
        begin
            count_reg <= count_next;
            phase_reg <= phase_next;
        end
    end

endmodule

// ----- rtl/core/button_auto_repeat.sv -----
// button auto repeat: per-button press and repeat detection, top level
//
// in channel: one request per update tick, button_lines bit p*6+b is
// player p, button b. out channel: one result per request, held_mask and
// press_mask in the same layout. cfg channel: cfg_index selects the
// delay (0), interval (1) or fast rate (2) register; other indexes are
// dropped. cfg_ready is always high; write only while no request is open.
// a request is registered on acceptance, then the twelve lane counters and
// the result register update together once the result register is empty
// or being read; one request per cycle sustained while out_ready stays high.
// when a result waits and out_ready is low the result register holds and the input register
// still takes one more request; in_ready drops only when both are full.
// reset clears all hold counters and phases, loads delay 15, interval 4,
// normal rate, and empties both registers. buttons outside PLAYERS and
// BUTTONS read as released and show zero in both masks.
`include "button_auto_repeat_macros.svh"

module button_auto_repeat
    import bar_pkg::*;
#(
    parameter int PLAYERS = 2,
    parameter int BUTTONS = 6
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [LINE_W-1:0]     button_lines,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [LINE_W-1:0]     held_mask,
    output logic [LINE_W-1:0]     press_mask,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    timing_t           timing;
    logic              s1_valid_reg;
    logic [LINE_W-1:0] lines_reg;
    logic              out_valid_reg;
    logic [LINE_W-1:0] held_reg;
    logic [LINE_W-1:0] press_reg;
    logic              advance;
    logic [LINE_W-1:0] lane_mask;
    logic [LINE_W-1:0] held_next;
    logic [LINE_W-1:0] press_next;

    bar_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .timing    (timing)
    );

    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;

    genvar gi;
    generate
        for (gi = 0; gi < LANES; gi++)
        begin : g_lane
            if ((gi / LANE_STRIDE) < PLAYERS && (gi % LANE_STRIDE) < BUTTONS)
            begin : g_used
                assign lane_mask[gi] = 1'b1;
                assign held_next[gi] = lines_reg[gi];
                bar_lane u_lane (
                    .clk    (clk),
                    .rst_n  (rst_n),
                    .update (advance),
                    .level  (lines_reg[gi]),
                    .timing (timing),
                    .press  (press_next[gi])
                );
            end
            else
            begin : g_unused
                assign lane_mask[gi]  = 1'b0;
                assign held_next[gi]  = 1'b0;
                assign press_next[gi] = 1'b0;
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                s1_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            lines_reg <= button_lines;
        if (advance)
        begin
            held_reg  <= held_next;
            press_reg <= press_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign held_mask  = held_reg;
    assign press_mask = press_reg;

    `BAR_ASSERT_SAME(a_press_within_held, clk, rst_n, out_valid_reg, (press_reg & ~held_reg) == '0)
    `BAR_ASSERT_SAME(a_unused_lanes_zero, clk, rst_n, out_valid_reg, (held_reg & ~lane_mask) == '0)
    `BAR_ASSERT_SAME(a_stall_only_when_full, clk, rst_n, !in_ready, s1_valid_reg && out_valid_reg && !out_ready)
    `BAR_ASSERT_NEXT(a_request_enters_stage, clk, rst_n, in_valid && in_ready, s1_valid_reg)

endmodule

// ----- tb/tb_button_auto_repeat.sv -----
// self-checking testbench for the button auto repeat block
`timescale 1ns / 100ps

module tb_button_auto_repeat
    import bar_pkg::*;
();

    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_GAP     = 8;
    localparam int PRINT_LIMIT = 40;
    // index with no register behind it, writes to it are dropped
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [LINE_W-1:0] held;
        logic [LINE_W-1:0] press;
    } tick_masks_t;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [LINE_W-1:0]     button_lines;
    logic                  out_valid;
    logic                  out_ready;
    logic [LINE_W-1:0]     held_mask;
    logic [LINE_W-1:0]     press_mask;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // predictor copy of the registers and the per-button counters
    logic [CFG_DATA_W-1:0] delay_reg;
    logic [CFG_DATA_W-1:0] interval_reg;
    logic                  fast_mode;
    logic [CNT_W-1:0]      hold_cnt [LANES];
    logic [CNT_W-1:0]      phase_cnt [LANES];

    tick_masks_t pending_masks [$];
    int          mismatch_count;
    int          cycle_count;
    bit          idle_on;
    bit          result_taken;
    int          long_stall_req;

    button_auto_repeat i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .button_lines (button_lines),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .held_mask    (held_mask),
        .press_mask   (press_mask),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void predict_tick(input logic [LINE_W-1:0] lines,
                                         output tick_masks_t masks);
        int scale;
        int delay_t;
        int interval_t;
        int cnt;
        int step;
        scale      = fast_mode ? 2 : 1;
        delay_t    = delay_reg * scale;
        interval_t = interval_reg * scale;
        if (interval_t == 0)
        begin
            interval_t = 1;
        end
        masks = '0;
        for (int lane = 0; lane < LANES; lane++)
        begin
            if (!lines[lane])
            begin
                hold_cnt[lane]  = '0;
                phase_cnt[lane] = '0;
            end
            else
            begin
                masks.held[lane] = 1'b1;
                cnt = hold_cnt[lane] + 1;
                if (cnt > delay_t + 1)
                begin
                    cnt = delay_t + 1;
                end
                // phase only runs once the count was already saturated
                if (hold_cnt[lane] >= delay_t + 1)
                begin
                    step = phase_cnt[lane] + 1;
                    phase_cnt[lane] = (step >= interval_t) ? '0 : step[CNT_W-1:0];
                end
                else
                begin
                    phase_cnt[lane] = '0;
                end
                hold_cnt[lane] = cnt[CNT_W-1:0];
                if (cnt == 1 || (cnt == delay_t + 1 && phase_cnt[lane] == 0))
                begin
                    masks.press[lane] = 1'b1;
                end
            end
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [LINE_W-1:0] want,
                                   input logic [LINE_W-1:0] got);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
        begin
            $display("%0t: %s: expected %03h, got %03h", $realtime, what, want, got);
        end
    endtask

    task automatic send_tick(input logic [LINE_W-1:0] lines);
        int          gap;
        tick_masks_t masks;
        gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
        @(negedge clk);
        repeat (gap)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        button_lines <= lines;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        predict_tick(lines, masks);
        pending_masks = {pending_masks, masks};
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_masks.size() > 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        wait_idle();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        case (idx)
            REG_DELAY:    delay_reg = data;
            REG_INTERVAL: interval_reg = data;
            REG_FAST:     fast_mode = data[0];
            default:      ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_timing(input logic [CFG_DATA_W-1:0] delay_v,
                                input logic [CFG_DATA_W-1:0] interval_v,
                                input logic [CFG_DATA_W-1:0] fast_v);
        write_reg(REG_DELAY, delay_v);
        write_reg(REG_INTERVAL, interval_v);
        write_reg(REG_FAST, fast_v);
    endtask

    // buttons mostly stay put for runs of ticks, with the odd burst of noise
    task automatic run_random(input int n, input int flip_div, input logic [LINE_W-1:0] keep);
        logic [LINE_W-1:0] lines;
        lines = LINE_W'($urandom);
        for (int k = 0; k < n; k++)
        begin
            if (k % 50 == 0)
            begin
                idle_on = ($urandom_range(0, 3) != 0);
            end
            if ($urandom_range(0, 19) == 0)
            begin
                lines = LINE_W'($urandom);
            end
            else
            begin
                for (int lane = 0; lane < LANES; lane++)
                begin
                    if ($urandom_range(0, flip_div - 1) == 0)
                    begin
                        lines[lane] = ~lines[lane];
                    end
                end
            end
            send_tick(lines | keep);
        end
    endtask

    // reset timing: first press, delay, then repeats every interval
    task automatic test_reset_timing();
        idle_on = 1'b1;
        send_tick('0);
        repeat (20) send_tick('1);
        send_tick(12'h555);
        send_tick(12'haaa);
        send_tick('0);
    endtask

    // timing changes while buttons stay down
    task automatic test_change_mid_hold();
        write_timing(8'd255, 8'd255, 8'd0);
        repeat (12) send_tick('1);
        // count is above the new saturation point and gets clamped
        write_reg(REG_DELAY, 8'd2);
        repeat (4) send_tick('1);
        write_reg(REG_DELAY, 8'd0);
        repeat (20) send_tick(12'h03f);
        // phase is past the new interval and wraps on its next step
        write_reg(REG_INTERVAL, 8'd5);
        repeat (6) send_tick(12'h03f);
    endtask

    task automatic test_dropped_writes();
        write_reg(REG_UNUSED, 8'h01);
        // only bit 0 of the fast rate write counts
        write_reg(REG_FAST, 8'hfe);
        run_random(40, 6, '0);
    endtask

    task automatic test_output_stall();
        wait_idle();
        idle_on = 1'b0;
        long_stall_req = 60;
        repeat (40) send_tick(LINE_W'($urandom));
    endtask

    task automatic test_timing_sweep();
        run_random(130, 12, '0);
        write_timing(8'd0, 8'd0, 8'd0);
        run_random(150, 4, '0);
        write_timing(8'd0, 8'd0, 8'd1);
        run_random(150, 4, '0);
        write_timing(8'd3, 8'd2, 8'd1);
        run_random(150, 8, '0);
        write_timing(8'd255, 8'd1, 8'd0);
        run_random(100, 30, 12'h800);
        // longest delay and interval, two buttons kept down throughout
        write_timing(8'd255, 8'd255, 8'd1);
        run_random(530, 10, 12'h801);
        repeat (3)
        begin
            write_timing(CFG_DATA_W'($urandom_range(0, 20)),
                         CFG_DATA_W'($urandom_range(0, 8)),
                         CFG_DATA_W'($urandom_range(0, 1)));
            run_random(100, 10, '0);
        end
    endtask

    initial
    begin : result_sink
        int gap_left;
        int long_stall_left;
        gap_left        = 0;
        long_stall_left = 0;
        out_ready       = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_stall_req > 0)
            begin
                long_stall_left = long_stall_req;
                long_stall_req  = 0;
            end
            if (result_taken)
            begin
                result_taken = 1'b0;
                gap_left = idle_on ? $urandom_range(0, MAX_GAP) : 0;
            end
            if (long_stall_left > 0)
            begin
                long_stall_left--;
                out_ready <= 1'b0;
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    initial
    begin : result_check
        tick_masks_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                result_taken = 1'b1;
                if (pending_masks.size() == 0)
                begin
                    report_mismatch("result with no request pending", '0, held_mask);
                end
                else
                begin
                    want = pending_masks.pop_front();
                    if (held_mask !== want.held)
                    begin
                        report_mismatch("held_mask", want.held, held_mask);
                    end
                    if (press_mask !== want.press)
                    begin
                        report_mismatch("press_mask", want.press, press_mask);
                    end
                end
            end
        end
    end

    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        button_lines   = '0;
        cfg_valid      = 1'b0;
        cfg_index      = REG_DELAY;
        cfg_data       = '0;
        mismatch_count = 0;
        idle_on        = 1'b1;
        result_taken   = 1'b0;
        long_stall_req = 0;
        delay_reg      = DELAY_RST;
        interval_reg   = INTERVAL_RST;
        fast_mode      = 1'b0;
        for (int lane = 0; lane < LANES; lane++)
        begin
            hold_cnt[lane]  = '0;
            phase_cnt[lane] = '0;
        end
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_timing();
        test_change_mid_hold();
        test_dropped_writes();
        test_output_stall();
        test_timing_sweep();

        wait_idle();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && pending_masks.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/bar_pkg.sv
rtl/core/bar_cfg.sv
rtl/core/bar_lane.sv
rtl/core/button_auto_repeat.sv
tb/tb_button_auto_repeat.sv
